@@ rtl/pwle_pkg.sv @@
package pwle_pkg;

  localparam int MAX_POINTS = 16;
  localparam int PT_IDX_W   = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int VAL_W = 32;
  localparam int DUR_W = 16;
  localparam int MS_W  = 32;
  // sum of all durations
  localparam int TOT_W = DUR_W + PT_IDX_W;

  // shared restoring divider: quotient bits per pass
  localparam int DIV_STEPS = VAL_W + 1;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);
  localparam int PROD_W    = DIV_STEPS + DUR_W;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_VALUE = 2'd2;

  // request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_EVAL  = 1'b1;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [DUR_W-1:0] dur;
  } point_t;

endpackage

@@ rtl/piecewise_linear_envelope.sv @@
// Sequence: a write item is done in the cycle it is accepted. An evaluate item with n points
//   in use sums the durations, folds elapsed time, divides for (t-1) mod total (only when
//   elapsed exceeds the total), searches for the segment, multiplies, divides (skipped on a
//   flat or zero-length segment) and hands the result on; n = 0 returns the start value.
// Throughput: one item at a time; in_stall_o holds the input until the sequencer is back in
//   idle, so table sweeps, the bit-serial divider and a stalled output hold it. Reset: config
//   registers clear to zero, sequencer idle, output empty; table and datapath regs are not cleared.
module piecewise_linear_envelope (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [pwle_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pwle_pkg::VAL_W-1:0]           cfg_wdata_i,
  // request channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 req_type_i,
  input  logic [3:0]                           point_index_i,
  input  logic signed [pwle_pkg::VAL_W-1:0]    point_value_i,
  input  logic [pwle_pkg::DUR_W-1:0]           point_duration_i,
  input  logic [pwle_pkg::MS_W-1:0]            elapsed_ms_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [pwle_pkg::VAL_W-1:0]    env_value_o
);

  localparam int IW = pwle_pkg::PT_IDX_W;
  localparam int CW = pwle_pkg::CNT_W;
  localparam int VW = pwle_pkg::VAL_W;
  localparam int DW = pwle_pkg::DUR_W;
  localparam int TW = pwle_pkg::TOT_W;
  localparam int SW = pwle_pkg::DIV_STEPS;
  localparam int PW = pwle_pkg::PROD_W;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SUM    = 3'd1; // sweep table, add durations
  localparam logic [2:0] S_PREP   = 3'd2; // fold elapsed time into 0..total
  localparam logic [2:0] S_MOD    = 3'd3; // divider computes (t-1) mod total
  localparam logic [2:0] S_SEARCH = 3'd4; // sweep table, find segment
  localparam logic [2:0] S_MUL    = 3'd5; // slope numerator
  localparam logic [2:0] S_DIV    = 3'd6; // divider computes numerator / duration
  localparam logic [2:0] S_FIN    = 3'd7; // hand result to output register

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [4:0]    num_points_q;
  logic          loop_mode_q;
  logic [VW-1:0] start_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_points_q  <= '0;
      loop_mode_q   <= 1'b0;
      start_value_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pwle_pkg::REG_NUM_POINTS:  num_points_q  <= cfg_wdata_i[4:0];
        pwle_pkg::REG_LOOP_MODE:   loop_mode_q   <= cfg_wdata_i[0];
        pwle_pkg::REG_START_VALUE: start_value_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // points in use, saturated to the table size
  logic [CW-1:0] n_use;
  assign n_use = (32'(num_points_q) > 32'(pwle_pkg::MAX_POINTS)) ?
                 CW'(pwle_pkg::MAX_POINTS) : CW'(num_points_q);

  // ---------------------------------------------------------------------------
  // Point table: one write port (write items), one read port (evaluation),
  // read data registered. Accesses never overlap: writes only in idle.
  // ---------------------------------------------------------------------------
  pwle_pkg::point_t mem [pwle_pkg::MAX_POINTS];
  pwle_pkg::point_t rd_q;
  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  logic             rd_en;
  logic [IW-1:0]    rd_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= '{value: point_value_i, dur: point_duration_i};
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Control and datapath registers
  // ---------------------------------------------------------------------------
  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;         // next table address to read
  logic          rd_vld_q, rd_vld_d;   // rd_q holds the entry at rd_idx_q
  logic [IW-1:0] rd_idx_q, rd_idx_d;
  logic [CW-1:0] n_q, n_d;
  logic [TW-1:0] total_q, total_d;
  logic [TW-1:0] before_q, before_d;   // start time of the current segment
  logic [VW-1:0] t_q, t_d;             // elapsed time, folded
  logic [VW-1:0] last_val_q, last_val_d;
  logic [VW-1:0] prev_val_q, prev_val_d;
  logic [VW-1:0] ev_q, ev_d;
  logic [VW-1:0] bv_q, bv_d;
  logic [DW-1:0] dur_q, dur_d;
  logic          neg_q, neg_d;
  logic [VW-1:0] res_q, res_d;
  // divider
  logic [TW-1:0] rem_q, rem_d;
  logic [SW-1:0] dvd_q, dvd_d;         // dividend in, quotient out
  logic [TW-1:0] dsr_q, dsr_d;
  logic [pwle_pkg::DCNT_W-1:0] dcnt_q, dcnt_d;
  // output register
  logic          out_valid_q, out_valid_d;
  logic [VW-1:0] env_q, env_d;

  // one restoring step: bring down one dividend bit, subtract if it fits
  logic [TW:0]   step_r;
  logic          step_ge;
  logic [TW-1:0] step_rem;
  logic [SW-1:0] step_dvd;

  always_comb begin
    step_r   = {rem_q, dvd_q[SW-1]};
    step_ge  = step_r >= {1'b0, dsr_q};
    step_rem = step_ge ? TW'(step_r - {1'b0, dsr_q}) : TW'(step_r);
    step_dvd = {dvd_q[SW-2:0], step_ge};
  end

  // slope numerator: |end - begin| * (t - segment start)
  logic signed [VW:0] diff;
  logic [VW:0]        diff_mag;
  logic [DW-1:0]      offs;
  logic [PW-1:0]      prod;

  always_comb begin
    diff     = $signed({ev_q[VW-1], ev_q}) - $signed({bv_q[VW-1], bv_q});
    diff_mag = diff[VW] ? (VW+1)'(-diff) : (VW+1)'(diff);
    offs     = DW'(t_q - VW'(before_q));
    prod     = PW'(diff_mag) * PW'(offs);
  end

  logic          in_acc;
  logic          at_last;
  logic [TW:0]   seg_end;
  logic [VW-1:0] quot;

  assign in_acc  = in_valid_i && (state_q == S_IDLE);
  assign at_last = rd_idx_q == IW'(n_q - CW'(1));
  assign seg_end = {1'b0, before_q} + (TW+1)'(rd_q.dur);
  assign quot    = step_dvd[VW-1:0];

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    n_d         = n_q;
    total_d     = total_q;
    before_d    = before_q;
    t_d         = t_q;
    last_val_d  = last_val_q;
    prev_val_d  = prev_val_q;
    ev_d        = ev_q;
    bv_d        = bv_q;
    dur_d       = dur_q;
    neg_d       = neg_q;
    res_d       = res_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    dsr_d       = dsr_q;
    dcnt_d      = dcnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    env_d       = env_q;
    mem_we      = 1'b0;
    mem_waddr   = IW'(point_index_i);
    rd_en       = 1'b0;
    rd_addr     = cnt_q[IW-1:0];

    // table sweeps: issue one read a cycle while addresses remain
    if ((state_q == S_SUM || state_q == S_SEARCH) && cnt_q < n_q) begin
      rd_en    = 1'b1;
      rd_vld_d = 1'b1;
      rd_idx_d = cnt_q[IW-1:0];
      cnt_d    = cnt_q + CW'(1);
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (req_type_i == pwle_pkg::REQ_WRITE) begin
            mem_we = 32'(point_index_i) < 32'(pwle_pkg::MAX_POINTS);
          end else if (n_use == '0) begin
            res_d   = start_value_q;
            state_d = S_FIN;
          end else begin
            n_d     = n_use;
            t_d     = elapsed_ms_i;
            cnt_d   = '0;
            total_d = '0;
            state_d = S_SUM;
          end
        end
      end
      S_SUM: begin
        if (rd_vld_q) begin
          total_d = total_q + TW'(rd_q.dur);
          if (at_last) begin
            last_val_d = rd_q.value;
            state_d    = S_PREP;
          end
        end
      end
      S_PREP: begin
        cnt_d    = '0;
        before_d = '0;
        state_d  = S_SEARCH;
        if (total_q == '0) begin
          t_d = '0;
        end else if (t_q > VW'(total_q)) begin
          rem_d   = '0;
          dvd_d   = SW'(t_q - VW'(1));
          dsr_d   = total_q;
          dcnt_d  = pwle_pkg::DCNT_W'(SW);
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        rem_d  = step_rem;
        dvd_d  = step_dvd;
        dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == pwle_pkg::DCNT_W'(1)) begin
          t_d     = VW'(step_rem) + VW'(1);
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (rd_vld_q) begin
          // first segment whose end time reaches t
          if (seg_end >= (TW+1)'(t_q) || at_last) begin
            ev_d  = rd_q.value;
            dur_d = rd_q.dur;
            if (rd_idx_q != '0) begin
              bv_d = prev_val_q;
            end else if (loop_mode_q) begin
              bv_d = last_val_q;
            end else begin
              bv_d = start_value_q;
            end
            state_d = S_MUL;
          end else begin
            before_d   = TW'(seg_end);
            prev_val_d = rd_q.value;
          end
        end
      end
      S_MUL: begin
        if (bv_q == ev_q || dur_q == '0) begin
          res_d   = ev_q;
          state_d = S_FIN;
        end else begin
          neg_d   = diff[VW];
          rem_d   = TW'(prod[PW-1:SW]);
          dvd_d   = prod[SW-1:0];
          dsr_d   = TW'(dur_q);
          dcnt_d  = pwle_pkg::DCNT_W'(SW);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d  = step_rem;
        dvd_d  = step_dvd;
        dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == pwle_pkg::DCNT_W'(1)) begin
          // quotient truncated toward zero, applied with the slope sign
          res_d   = bv_q + (neg_q ? (~quot + VW'(1)) : quot);
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          env_d       = res_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_vld_q    <= rd_vld_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    n_q        <= n_d;
    total_q    <= total_d;
    before_q   <= before_d;
    t_q        <= t_d;
    last_val_q <= last_val_d;
    prev_val_q <= prev_val_d;
    ev_q       <= ev_d;
    bv_q       <= bv_d;
    dur_q      <= dur_d;
    neg_q      <= neg_d;
    res_q      <= res_d;
    rem_q      <= rem_d;
    dvd_q      <= dvd_d;
    dsr_q      <= dsr_d;
    env_q      <= env_d;
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign env_value_o = env_q;

endmodule

@@ tb/sv/piecewise_linear_envelope_tb.sv @@
module piecewise_linear_envelope_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // index 3 is not mapped to any register; writes there must be dropped
  localparam logic [pwle_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // the padding covers the longest evaluate at 16 points; write items make no result,
  // so wait this long after the last result before touching a register
  localparam int DRAIN_PAD    = 150;
  localparam int RANDOM_ITEMS = 1450;
  localparam int CALM_TAIL    = 150;   // last items run with no idling
  localparam int HOLD_CYCLES  = 300;   // long result-side back-pressure

  // ---------------------------------------------------------------------------
  // DUT signals
  // ---------------------------------------------------------------------------
  logic                                clk_i;
  logic                                rst_ni;
  logic                                cfg_we_i;
  logic [pwle_pkg::CFG_IDX_W-1:0]      cfg_index_i;
  logic [pwle_pkg::VAL_W-1:0]          cfg_wdata_i;
  logic                                in_valid_i;
  logic                                in_stall_o;
  logic                                req_type_i;
  logic [3:0]                          point_index_i;
  logic signed [pwle_pkg::VAL_W-1:0]   point_value_i;
  logic [pwle_pkg::DUR_W-1:0]          point_duration_i;
  logic [pwle_pkg::MS_W-1:0]           elapsed_ms_i;
  logic                                out_valid_o;
  logic                                out_stall_i;
  logic signed [pwle_pkg::VAL_W-1:0]   env_value_o;

  piecewise_linear_envelope dut (.*);

  // ---------------------------------------------------------------------------
  // Envelope predictor state: point table, registers, pending results
  // ---------------------------------------------------------------------------
  logic [pwle_pkg::VAL_W-1:0]      lvl_tab  [pwle_pkg::MAX_POINTS];
  logic [pwle_pkg::DUR_W-1:0]      span_tab [pwle_pkg::MAX_POINTS];
  logic [pwle_pkg::MAX_POINTS-1:0] loaded;        // slots written since start of run
  logic [4:0]                      cfg_count;
  logic                            cfg_wrap;
  logic [pwle_pkg::VAL_W-1:0]      cfg_origin;
  logic [pwle_pkg::VAL_W-1:0]      env_due [$];   // expected env_value, oldest first
  logic [pwle_pkg::VAL_W-1:0]      env_want;

  // directed stimulus table
  typedef struct packed {
    logic                           is_cfg;
    logic [pwle_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [pwle_pkg::VAL_W-1:0]     wdata;
    logic                           req;
    logic [3:0]                     slot;
    logic [pwle_pkg::VAL_W-1:0]     value;
    logic [pwle_pkg::DUR_W-1:0]     dur;
    logic [pwle_pkg::MS_W-1:0]      ms;
    logic                           has_gold;   // expected value typed in by hand
    logic [pwle_pkg::VAL_W-1:0]     gold;
  } step_row_t;

  step_row_t plan [$];

  // run bookkeeping
  int items_sent    = 0;
  int evals_sent    = 0;
  int results_seen  = 0;
  int mismatches    = 0;
  int phases        = 0;
  int sat_phases    = 0;
  int in_gap_pct    = 0;
  int out_stall_pct = 0;
  bit calm          = 1'b0;
  bit touched       = 1'b0;   // an item went in since the last drain
  bit hold_req      = 1'b0;
  bit hold_done     = 1'b0;

  // ---------------------------------------------------------------------------
  // Clock and the run limit
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // The slowest legal run, with its gaps, busy time, stalls, register drains
  // and the long hold, ends well within the 18 ms limit.
  initial begin
    #18_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int points_live();
    return (cfg_count > pwle_pkg::MAX_POINTS) ? pwle_pkg::MAX_POINTS : int'(cfg_count);
  endfunction

  // sum of durations of slots 0..upto-1
  function automatic longint unsigned cycle_span(input int upto);
    longint unsigned sum;
    sum = 0;
    for (int i = 0; i < upto; i++) sum += span_tab[i];
    return sum;
  endfunction

  function automatic logic [pwle_pkg::VAL_W-1:0] envelope_at(
      input logic [pwle_pkg::MS_W-1:0] ms);
    int              n;
    int              seg;
    longint unsigned total;
    longint unsigned t;
    longint unsigned acc;
    longint          from_v;
    longint          to_v;
    longint          off;
    longint          width;
    longint          res;
    n = points_live();
    if (n == 0) return cfg_origin;
    total = cycle_span(n);
    // fold elapsed time into 0..total; an all-zero table pins time at 0
    t = ms;
    if (total == 0) t = 0;
    else if (t > total) t = ((t - 1) % total) + 1;
    // first segment whose running end reaches t
    acc = 0;
    seg = 0;
    for (int i = 0; i < n; i++) begin
      seg = i;
      if (acc + span_tab[i] >= t) break;
      acc += span_tab[i];
    end
    to_v = $signed(lvl_tab[seg]);
    if (seg > 0) from_v = $signed(lvl_tab[seg - 1]);
    else if (cfg_wrap) from_v = $signed(lvl_tab[n - 1]);
    else from_v = $signed(cfg_origin);
    width = span_tab[seg];
    if (from_v == to_v || width == 0) return lvl_tab[seg];
    off = t - acc;
    // 64-bit product; SV division truncates toward zero
    res = from_v + (to_v - from_v) * off / width;
    return res[pwle_pkg::VAL_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting and result checking
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input logic [pwle_pkg::VAL_W-1:0] got,
                               input logic [pwle_pkg::VAL_W-1:0] want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (env_due.size() == 0) begin
        note_mismatch("result with nothing pending", env_value_o, '0);
      end else begin
        env_want = env_due.pop_front();
        if (env_value_o !== env_want) note_mismatch("env_value", env_value_o, env_want);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side back-pressure: short random bursts, plus one long hold that
  // lets the block back up into its input while items keep being offered.
  // ---------------------------------------------------------------------------
  initial begin
    int burst;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
        out_stall_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < out_stall_pct) begin
        burst = $urandom_range(1, 4);
        out_stall_i <= 1'b1;
        repeat (burst) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  // Offer one item, hold it through stalls, and update the predictor at the
  // accepting edge so the next item sees the table as the block does.
  task automatic offer_item(input logic req, input logic [3:0] slot,
                            input logic [pwle_pkg::VAL_W-1:0] value,
                            input logic [pwle_pkg::DUR_W-1:0] dur,
                            input logic [pwle_pkg::MS_W-1:0] ms, input logic has_gold,
                            input logic [pwle_pkg::VAL_W-1:0] gold);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < in_gap_pct) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    req_type_i       <= req;
    point_index_i    <= slot;
    point_value_i    <= value;
    point_duration_i <= dur;
    elapsed_ms_i     <= ms;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    if (req == pwle_pkg::REQ_WRITE) begin
      lvl_tab[slot]  = value;
      span_tab[slot] = dur;
      loaded[slot]   = 1'b1;
    end else begin
      env_due.push_back(has_gold ? gold : envelope_at(ms));
      evals_sent++;
    end
    items_sent++;
    touched = 1'b1;
  endtask

  // Let everything in flight come out; write items leave no trace on the
  // result side, so pad by the worst evaluate latency afterwards.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (env_due.size() != 0) @(posedge clk_i);
    if (touched) repeat (DRAIN_PAD) @(posedge clk_i);
    touched = 1'b0;
  endtask

  task automatic set_reg(input logic [pwle_pkg::CFG_IDX_W-1:0] idx,
                         input logic [pwle_pkg::VAL_W-1:0] data);
    settle_block();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      pwle_pkg::REG_NUM_POINTS:  cfg_count  = data[4:0];
      pwle_pkg::REG_LOOP_MODE:   cfg_wrap   = data[0];
      pwle_pkg::REG_START_VALUE: cfg_origin = data;
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic step_row_t cfg_row(input logic [pwle_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [pwle_pkg::VAL_W-1:0] data);
    step_row_t r;
    r         = '0;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.wdata   = data;
    return r;
  endfunction

  function automatic step_row_t item_row(input logic req, input logic [3:0] slot,
                                         input logic [pwle_pkg::VAL_W-1:0] value,
                                         input logic [pwle_pkg::DUR_W-1:0] dur,
                                         input logic [pwle_pkg::MS_W-1:0] ms,
                                         input logic has_gold,
                                         input logic [pwle_pkg::VAL_W-1:0] gold);
    step_row_t r;
    r          = '0;
    r.req      = req;
    r.slot     = slot;
    r.value    = value;
    r.dur      = dur;
    r.ms       = ms;
    r.has_gold = has_gold;
    r.gold     = gold;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int                         target;
    int                         live;
    int                         hole;
    int                         batch;
    int                         n_pick;
    int                         k;
    logic [3:0]                 slot;
    logic [pwle_pkg::VAL_W-1:0] value;
    logic [pwle_pkg::DUR_W-1:0] dur;
    logic [pwle_pkg::MS_W-1:0]  ms;
    longint unsigned            total;

    // every input known from time zero
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_index_i      <= pwle_pkg::REG_NUM_POINTS;
    cfg_wdata_i      <= '0;
    in_valid_i       <= 1'b0;
    req_type_i       <= pwle_pkg::REQ_WRITE;
    point_index_i    <= '0;
    point_value_i    <= '0;
    point_duration_i <= '0;
    elapsed_ms_i     <= '0;

    for (int i = 0; i < pwle_pkg::MAX_POINTS; i++) begin
      lvl_tab[i]  = '0;
      span_tab[i] = '0;
    end
    loaded     = '0;
    cfg_count  = '0;
    cfg_wrap   = 1'b0;
    cfg_origin = '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed table ----
    // empty table right after reset: start_value, which resets to zero
    plan.push_back(item_row(pwle_pkg::REQ_EVAL, 4'd0, '0, '0, 32'd0, 1'b1, 32'h0000_0000));
    plan.push_back(cfg_row(pwle_pkg::REG_START_VALUE, 32'h8000_0000));
    plan.push_back(item_row(pwle_pkg::REQ_EVAL, 4'd0, '0, '0, 32'hFFFF_FFFF, 1'b1,
                            32'h8000_0000));
    // four points: full-scale ramp, zero-length step, ramp, flat segment
    plan.push_back(item_row(pwle_pkg::REQ_WRITE, 4'd0, 32'h7FFF_FFFF, 16'hFFFF, '0, 1'b0, '0));
    plan.push_back(item_row(pwle_pkg::REQ_WRITE, 4'd1, 32'h8000_0000, 16'd0, '0, 1'b0, '0));
    plan.push_back(item_row(pwle_pkg::REQ_WRITE, 4'd2, 32'h0001_0000, 16'd10, '0, 1'b0, '0));
    plan.push_back(item_row(pwle_pkg::REQ_WRITE, 4'd3, 32'h0001_0000, 16'd5, '0, 1'b0, '0));
    plan.push_back(cfg_row(pwle_pkg::REG_NUM_POINTS, 32'd4));
    // segment 0 ends: min at t=0, max at t=65535 (full-range interpolation)
    plan.push_back(item_row(pwle_pkg::REQ_EVAL, 4'd0, '0, '0, 32'd0, 1'b1, 32'h8000_0000));
    plan.push_back(item_row(pwle_pkg::REQ_EVAL, 4'd0, '0, '0, 32'd65535, 1'b1,
                            32'h7FFF_FFFF));
    // zero-length segment 1 is skipped, lands in segment 2
    plan.push_back(item_row(pwle_pkg::REQ_EVAL, 4'd0, '0, '0, 32'd65536, 1'b0, '0));
    // t == total, flat last segment gives its end value
    plan.push_back(item_row(pwle_pkg::REQ_EVAL, 4'd0, '0, '0, 32'd65550, 1'b1,
                            32'h0001_0000));
    // wrap-around: far past total, and one past total
    plan.push_back(item_row(pwle_pkg::REQ_EVAL, 4'd0, '0, '0, 32'hFFFF_FFFF, 1'b0, '0));
    plan.push_back(item_row(pwle_pkg::REQ_EVAL, 4'd0, '0, '0, 32'd65551, 1'b0, '0));
    // loop mode: segment 0 begins at the last point's value
    plan.push_back(cfg_row(pwle_pkg::REG_LOOP_MODE, 32'd1));
    plan.push_back(item_row(pwle_pkg::REQ_EVAL, 4'd0, '0, '0, 32'd0, 1'b1, 32'h0001_0000));
    plan.push_back(item_row(pwle_pkg::REQ_EVAL, 4'd0, '0, '0, 32'd30000, 1'b0, '0));
    // all durations zero: time pinned to 0, result is point 0's value
    plan.push_back(item_row(pwle_pkg::REQ_WRITE, 4'd0, 32'h0000_DEAD, 16'd0, '0, 1'b0, '0));
    plan.push_back(cfg_row(pwle_pkg::REG_NUM_POINTS, 32'd2));
    plan.push_back(item_row(pwle_pkg::REQ_EVAL, 4'd0, '0, '0, 32'd12345, 1'b1,
                            32'h0000_DEAD));
    // top slot, all-ones payload, then an unmapped register write
    plan.push_back(item_row(pwle_pkg::REQ_WRITE, 4'd15, 32'hFFFF_FFFF, 16'hFFFF, '0, 1'b0,
                            '0));
    plan.push_back(cfg_row(REG_SPARE, 32'hFFFF_FFFF));
    plan.push_back(item_row(pwle_pkg::REQ_EVAL, 4'd0, '0, '0, 32'd1, 1'b1, 32'h0000_DEAD));

    in_gap_pct    = 20;
    out_stall_pct = 20;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) set_reg(plan[i].reg_idx, plan[i].wdata);
      else offer_item(plan[i].req, plan[i].slot, plan[i].value, plan[i].dur,
                      plan[i].ms, plan[i].has_gold, plan[i].gold);
    end

    // ---- random phases: new register settings, then a burst of items ----
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      calm = (target - items_sent) <= CALM_TAIL;
      case ($urandom_range(0, 2))
        0: in_gap_pct = 0;
        1: in_gap_pct = 15;
        default: in_gap_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0: out_stall_pct = 0;
        1: out_stall_pct = 15;
        default: out_stall_pct = 40;
      endcase

      // point count: mostly short tables so times wrap often
      case ($urandom_range(0, 9))
        0: n_pick = 0;
        1: n_pick = pwle_pkg::MAX_POINTS;
        2: n_pick = $urandom_range(pwle_pkg::MAX_POINTS + 1, 31);
        3: n_pick = 1;
        default: n_pick = $urandom_range(2, 6);
      endcase
      if (phases == 0) n_pick = 31;     // saturating count, fills the table
      if (n_pick > pwle_pkg::MAX_POINTS) sat_phases++;
      set_reg(pwle_pkg::REG_NUM_POINTS, 32'(n_pick));
      if (phases == 0 || $urandom_range(0, 1) == 1)
        set_reg(pwle_pkg::REG_LOOP_MODE, 32'($urandom_range(0, 1)));
      if (phases == 0 || $urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 4))
          0: value = 32'h8000_0000;
          1: value = 32'h7FFF_FFFF;
          2: value = '0;
          default: value = $urandom;
        endcase
        set_reg(pwle_pkg::REG_START_VALUE, value);
      end
      if ($urandom_range(0, 7) == 0) set_reg(REG_SPARE, $urandom);

      // one early phase gets the long result-side hold
      if (phases == 2) hold_req <= 1'b1;

      batch = $urandom_range(20, 70);
      k = 0;
      while (k < batch && items_sent < target) begin
        calm = (target - items_sent) <= CALM_TAIL;
        live = points_live();
        // never evaluate over a slot that has not been loaded
        hole = -1;
        for (int s = live - 1; s >= 0; s--) if (!loaded[s]) hole = s;

        if (hole >= 0 || $urandom_range(0, 3) == 0) begin
          slot = (hole >= 0) ? 4'(hole) : 4'($urandom_range(0, pwle_pkg::MAX_POINTS - 1));
          case ($urandom_range(0, 7))
            0: value = (slot > 0) ? lvl_tab[slot - 4'd1] : cfg_origin;  // flat segment
            1: value = 32'h7FFF_FFFF;
            2: value = 32'h8000_0000;
            3: value = 32'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
            default: value = $urandom;
          endcase
          case ($urandom_range(0, 9))
            0: dur = '0;
            1: dur = 16'hFFFF;
            2, 3: dur = 16'($urandom);
            default: dur = 16'($urandom_range(1, 40));
          endcase
          offer_item(pwle_pkg::REQ_WRITE, slot, value, dur, $urandom, 1'b0, '0);
        end else begin
          total = cycle_span(live);
          case ($urandom_range(0, 7))
            0: ms = $urandom;
            1: ms = '0;
            2: ms = 32'hFFFF_FFFF;
            3: ms = 32'(total);
            4: begin
              // around a segment boundary
              if (live > 0)
                ms = 32'(cycle_span($urandom_range(1, live))) + 32'($urandom_range(0, 2)) - 1;
              else
                ms = $urandom;
            end
            default: ms = $urandom_range(0, 32'(3 * total + 2));
          endcase
          offer_item(pwle_pkg::REQ_EVAL, 4'($urandom), $urandom, 16'($urandom), ms, 1'b0,
                     '0);
        end
        k++;
      end
      phases++;
    end

    // ---- wrap up ----
    calm = 1'b1;
    settle_block();
    $display("Covered %0d items (%0d evaluates, %0d results) over %0d register settings,",
             items_sent, evals_sent, results_seen, phases);
    $display("  %0d of them with a saturating point count; %0d mismatches, %0d left pending.",
             sat_phases, mismatches, env_due.size());
    if (mismatches == 0 && env_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
